// ===== sv/murmurhash2_key_hasher_assert.svh =====
// Assertion helpers; clk and arst_n are taken from the including scope.
`ifndef MURMURHASH2_KEY_HASHER_ASSERT_SVH
`define MURMURHASH2_KEY_HASHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MMH2_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMH2_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mmh2_pkg.sv =====
package mmh2_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned VB_W   = 3;

	localparam logic [WORD_W-1:0] MIX_MUL    = 32'h5bd1e995;
	localparam logic [WORD_W-1:0] SEED_RESET = 32'h34a4b627;

	localparam int unsigned WORD_SHIFT  = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	// Register indexes on the configuration port
	localparam logic REG_HASH_SEED = 1'b0;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_K1,
		CMD_K2,
		CMD_HF,
		CMD_TAIL,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		logic take_key;
		cmd_t op;
	} dp_ctl_t;

endpackage

// ===== sv/mmh2_dp.sv =====
module mmh2_dp
	import mmh2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_ctl_t           ctl,
	input  logic [WORD_W-1:0] seed,
	input  logic [WORD_W-1:0] key_word,
	input  logic [VB_W-1:0]   valid_bytes,
	input  logic [WORD_W-1:0] key_length,
	input  logic              first_word,
	output logic [WORD_W-1:0] hash_value
);

	logic [WORD_W-1:0] k_q;
	logic [WORD_W-1:0] h_q;
	logic [WORD_W-1:0] out_q;
	logic [WORD_W-1:0] key_masked;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] prod;

	// Keep only the valid tail bytes; four or more means a full word
	always_comb begin
		case (valid_bytes)
			3'd1:    key_masked = {24'd0, key_word[7:0]};
			3'd2:    key_masked = {16'd0, key_word[15:0]};
			3'd3:    key_masked = {8'd0, key_word[23:0]};
			default: key_masked = key_word;
		endcase
	end

	// Single shared constant multiplier
	always_comb begin
		unique case (ctl.op)
			CMD_K1:   mul_a = k_q;
			CMD_K2:   mul_a = k_q ^ (k_q >> WORD_SHIFT);
			CMD_HF:   mul_a = h_q;
			CMD_TAIL: mul_a = h_q ^ k_q;
			CMD_FIN:  mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default:  mul_a = h_q;
		endcase
	end

	assign prod = WORD_W'(mul_a * MIX_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (ctl.take_key) begin
			if (first_word) begin
				h_q <= seed ^ key_length;
			end
		end else if (ctl.op == CMD_HF) begin
			h_q <= prod ^ k_q;
		end else if (ctl.op == CMD_TAIL) begin
			h_q <= prod;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_key) begin
			k_q <= key_masked;
		end else if (ctl.op == CMD_K1 || ctl.op == CMD_K2) begin
			k_q <= prod;
		end
		if (ctl.op == CMD_FIN) begin
			out_q <= prod ^ (prod >> FIN_SHIFT_B);
		end
	end

	assign hash_value = out_q;

endmodule

// ===== sv/mmh2_ctrl.sv =====
module mmh2_ctrl
	import mmh2_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [VB_W-1:0] valid_bytes,
	input  logic            last_word,
	output logic            out_valid,
	input  logic            out_ready,
	output dp_ctl_t         ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_K1,
		S_K2,
		S_HF,
		S_TAIL,
		S_FIN
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   out_valid_q;
	logic   accept;
	logic   fin_go;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// Finish only once the output register is free or being drained
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		ctl.take_key = accept;
		unique case (state_q)
			S_K1:    ctl.op = CMD_K1;
			S_K2:    ctl.op = CMD_K2;
			S_HF:    ctl.op = CMD_HF;
			S_TAIL:  ctl.op = CMD_TAIL;
			S_FIN:   ctl.op = fin_go ? CMD_FIN : CMD_NONE;
			default: ctl.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= last_word;
						if (valid_bytes[2]) begin
							state_q <= S_K1;
						end else if (valid_bytes != '0) begin
							state_q <= S_TAIL;
						end else if (last_word) begin
							state_q <= S_FIN;
						end
					end
				end
				S_K1: state_q <= S_K2;
				S_K2: state_q <= S_HF;
				S_HF, S_TAIL: begin
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/murmurhash2_key_hasher.sv =====
// A request is taken only in idle. A full word (4 valid bytes) then runs the K1, K2 and
// HF multiply steps, a word with 1 to 3 bytes runs the TAIL step, an empty word none;
// a last word then runs the FIN step, which waits until the output register is free
// or being drained, and the hash is shown after it. The next request is taken only
// after these steps; one shared 32x32 constant multiplier serves every step. Reset
// clears control, the running hash to zero and hash_seed to 0x34a4b627.
`include "murmurhash2_key_hasher_assert.svh"

module murmurhash2_key_hasher
	import mmh2_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // key_word[31:0], valid_bytes[34:32], key_length[66:35], zero pad
	input  logic        s_axis_tuser,  // first_word
	input  logic        s_axis_tlast,  // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // hash_value[31:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [WORD_W-1:0] seed_q;
	dp_ctl_t           ctl;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_HASH_SEED) begin
			seed_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_HASH_SEED) ? seed_q : '0;

	mmh2_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.valid_bytes (s_axis_tdata[34:32]),
		.last_word   (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.ctl         (ctl)
	);

	mmh2_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.seed        (seed_q),
		.key_word    (s_axis_tdata[31:0]),
		.valid_bytes (s_axis_tdata[34:32]),
		.key_length  (s_axis_tdata[66:35]),
		.first_word  (s_axis_tuser),
		.hash_value  (m_axis_tdata)
	);

	`MMH2_ASSERT_NEXT(a_full_word_busy,
		s_axis_tvalid && s_axis_tready && s_axis_tdata[34],
		!s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready,
		"full word did not run three multiply steps")
	`MMH2_ASSERT_NEXT(a_empty_word_quick,
		s_axis_tvalid && s_axis_tready && !s_axis_tlast && s_axis_tdata[34:32] == 3'd0,
		s_axis_tready,
		"empty non-last word did not return to idle")
	`MMH2_ASSERT_SAME(a_result_after_work,
		$rose(m_axis_tvalid),
		!$past(s_axis_tready),
		"result raised without finalization step")

endmodule
